// ----- rtl/mbs_pkg.sv -----
// Shared constants, types and control structs for the median background subtraction block.
`timescale 1ns / 1ps

package mbs_pkg;

  localparam int HISTORY_FRAMES = 3;
  localparam int MAX_PIXELS     = 131072;

  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int ROW_W    = HISTORY_FRAMES * PIX_W;
  localparam int POS_W    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SLOT_W   = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
  localparam int SEEN_W   = $clog2(HISTORY_FRAMES + 2);
  localparam int RANK_W   = $clog2(HISTORY_FRAMES + 1);
  localparam int MED_IDX  = HISTORY_FRAMES / 2;

  // Gray conversion: (1868*B + 9617*G + 4899*R + 8192) >> 14.
  localparam int PROD_B_W   = 19;
  localparam int PROD_G_W   = 22;
  localparam int PROD_R_W   = 21;
  localparam int SUM_W      = 23;
  localparam int GRAY_SHIFT = 14;
  localparam logic [10:0]      COEF_B     = 11'd1868;
  localparam logic [13:0]      COEF_G     = 14'd9617;
  localparam logic [12:0]      COEF_R     = 13'd4899;
  localparam logic [SUM_W-1:0] GRAY_ROUND = 23'd8192;

  localparam logic [CH_W-1:0] THRESH_RESET = 8'd25;

  // Channel positions inside a stored pixel word.
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  typedef logic [CH_W-1:0] chan_t;
  typedef logic [2:0][CH_W-1:0] diff_t;

  // Register load strobes for the four stages behind the input.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ctl_t;

endpackage

// ----- rtl/mbs_history_mem.sv -----
// Frame history memory: one row per pixel position, one 24-bit lane per stored frame.
`timescale 1ns / 1ps

module mbs_history_mem (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [mbs_pkg::POS_W-1:0]        rd_addr,
  output logic [mbs_pkg::ROW_W-1:0]        rd_row,
  input  logic                             wr_en,
  input  logic [mbs_pkg::POS_W-1:0]        wr_addr,
  input  logic [mbs_pkg::SLOT_W-1:0]       wr_slot,
  input  logic [mbs_pkg::PIX_W-1:0]        wr_pix
);

  logic [mbs_pkg::ROW_W-1:0] mem [mbs_pkg::MAX_PIXELS];
  logic [mbs_pkg::ROW_W-1:0] rd_row_r;

  // Read and write of the same row in one cycle returns the old row.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
    for (int l = 0; l < mbs_pkg::HISTORY_FRAMES; l++) begin
      if (wr_en && (wr_slot == mbs_pkg::SLOT_W'(l))) begin
        mem[wr_addr][l*mbs_pkg::PIX_W +: mbs_pkg::PIX_W] <= wr_pix;
      end
    end
  end

  assign rd_row = rd_row_r;

endmodule

// ----- rtl/mbs_median.sv -----
// Per-channel upper median of the stored frames and saturated background-minus-current.
`timescale 1ns / 1ps

module mbs_median (
  input  logic                         clk,
  input  mbs_pkg::pipe_ctl_t           ctl,
  input  logic [mbs_pkg::ROW_W-1:0]    row,
  input  logic [mbs_pkg::PIX_W-1:0]    cur,
  output mbs_pkg::diff_t               diff
);

  logic [mbs_pkg::ROW_W-1:0] vals2_r;
  logic [mbs_pkg::PIX_W-1:0] cur2_r;
  logic [2:0][mbs_pkg::HISTORY_FRAMES-1:0][mbs_pkg::RANK_W-1:0] rank_nxt, rank2_r;
  mbs_pkg::diff_t diff_nxt, diff3_r;

  // Stable rank of each value: smaller ones plus equal ones in earlier slots.
  // The value of rank HISTORY_FRAMES/2 is the upper median.
  always_comb begin
    logic [mbs_pkg::HISTORY_FRAMES-1:0] below;
    mbs_pkg::chan_t vi, vj;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < mbs_pkg::HISTORY_FRAMES; i++) begin
        vi = row[i*mbs_pkg::PIX_W + c*mbs_pkg::CH_W +: mbs_pkg::CH_W];
        for (int j = 0; j < mbs_pkg::HISTORY_FRAMES; j++) begin
          vj = row[j*mbs_pkg::PIX_W + c*mbs_pkg::CH_W +: mbs_pkg::CH_W];
          below[j] = (vj < vi) || ((j < i) && (vj == vi));
        end
        rank_nxt[c][i] = mbs_pkg::RANK_W'($countones(below));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      vals2_r <= row;
      cur2_r  <= cur;
      rank2_r <= rank_nxt;
    end
  end

  always_comb begin
    mbs_pkg::chan_t med, cv;
    for (int c = 0; c < 3; c++) begin
      med = '0;
      for (int i = 0; i < mbs_pkg::HISTORY_FRAMES; i++) begin
        if (rank2_r[c][i] == mbs_pkg::RANK_W'(mbs_pkg::MED_IDX)) begin
          med = med | vals2_r[i*mbs_pkg::PIX_W + c*mbs_pkg::CH_W +: mbs_pkg::CH_W];
        end
      end
      cv = cur2_r[c*mbs_pkg::CH_W +: mbs_pkg::CH_W];
      diff_nxt[c] = (med > cv) ? (med - cv) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      diff3_r <= diff_nxt;
    end
  end

  assign diff = diff3_r;

endmodule

// ----- rtl/mbs_gray.sv -----
// Weighted gray conversion of the channel differences and the foreground threshold test.
`timescale 1ns / 1ps

module mbs_gray (
  input  logic                          clk,
  input  mbs_pkg::pipe_ctl_t            ctl,
  input  mbs_pkg::diff_t                diff,
  input  mbs_pkg::chan_t                threshold,
  output mbs_pkg::chan_t                gray,
  output logic                          foreground
);

  logic [mbs_pkg::PROD_B_W-1:0] prod_b_r;
  logic [mbs_pkg::PROD_G_W-1:0] prod_g_r;
  logic [mbs_pkg::PROD_R_W-1:0] prod_r_r;
  logic [mbs_pkg::SUM_W-1:0]    sum;

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      prod_b_r <= mbs_pkg::PROD_B_W'(mbs_pkg::COEF_B) *
                  mbs_pkg::PROD_B_W'(diff[mbs_pkg::CH_BLUE]);
      prod_g_r <= mbs_pkg::PROD_G_W'(mbs_pkg::COEF_G) *
                  mbs_pkg::PROD_G_W'(diff[mbs_pkg::CH_GREEN]);
      prod_r_r <= mbs_pkg::PROD_R_W'(mbs_pkg::COEF_R) *
                  mbs_pkg::PROD_R_W'(diff[mbs_pkg::CH_RED]);
    end
  end

  assign sum = mbs_pkg::SUM_W'(prod_b_r) + mbs_pkg::SUM_W'(prod_g_r) +
               mbs_pkg::SUM_W'(prod_r_r) + mbs_pkg::GRAY_ROUND;
  assign gray       = sum[mbs_pkg::GRAY_SHIFT +: mbs_pkg::CH_W];
  assign foreground = (gray > threshold);

endmodule

// ----- rtl/median_background_subtraction.sv -----
// Top level of the temporal median background subtraction block.
`timescale 1ns / 1ps

// Pixels enter on the in_ stream in raster order, blue, green and red packed in
// in_tdata, with in_tlast on the last pixel of each frame. Each pixel is
// compared with the per-channel upper median of the same position in the
// stored frames, and the gray difference and foreground flag leave on the
// out_ stream, with out_tlast copied from in_tlast. The user writes the
// threshold through the cfg_ channel, one beat per write, only while the block
// is idle; the block does not enforce this. Throughput is one pixel per clock
// unless the receiver stalls: the history memory row for a position is read and
// the oldest lane of that row written in the same cycle, so neighboring pixels
// never wait on each other. During the first HISTORY_FRAMES+1 frames pixels are
// stored but give no result beat. Reset clears the position, slot and frame
// counters and sets the threshold to 25; the history memory is not cleared.
// While rst_n is low, in_tready and cfg_ready stay low. When the receiver
// stalls, the five stages (memory read, rank, median/subtract, multiply,
// output register) fill and in_tready falls only once every stage holds a beat.
module median_background_subtraction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // gray_difference [7:0]
  output logic        out_tuser,  // foreground [0]
  output logic        out_tlast,  // frame_end_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // fg_threshold [7:0]
);

  logic [mbs_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [mbs_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [mbs_pkg::SEEN_W-1:0] seen_r, seen_nxt;
  mbs_pkg::chan_t             thresh_r;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic fe1_r, fe2_r, fe3_r, fe4_r, fe_o_r;
  logic rdy1, rdy2, rdy3, rdy4, rdyo;
  logic accept, warm_done;
  logic [mbs_pkg::PIX_W-1:0] cur1_r;
  logic [mbs_pkg::ROW_W-1:0] row;
  mbs_pkg::pipe_ctl_t        ctl;
  mbs_pkg::diff_t            diff;
  mbs_pkg::chan_t            gray, gray_o_r;
  logic                      fg, fg_o_r;

  assign rdyo = !vo_r || out_tready;
  assign rdy4 = !v4_r || rdyo;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_tready = rdy1 && rst_n;
  assign accept    = in_tvalid && in_tready;
  assign warm_done = (seen_r == mbs_pkg::SEEN_W'(mbs_pkg::HISTORY_FRAMES + 1));

  assign ctl.ld1 = rdy1;
  assign ctl.ld2 = rdy2;
  assign ctl.ld3 = rdy3;
  assign ctl.ld4 = rdy4;

  always_comb begin
    pos_nxt  = pos_r;
    slot_nxt = slot_r;
    seen_nxt = seen_r;
    if (accept) begin
      if (in_tlast) begin
        pos_nxt  = '0;
        slot_nxt = (slot_r == mbs_pkg::SLOT_W'(mbs_pkg::HISTORY_FRAMES - 1)) ?
                   '0 : slot_r + 1'b1;
        if (!warm_done) begin
          seen_nxt = seen_r + 1'b1;
        end
      end else begin
        pos_nxt = (pos_r == mbs_pkg::POS_W'(mbs_pkg::MAX_PIXELS - 1)) ? '0 : pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      slot_r   <= '0;
      seen_r   <= '0;
      thresh_r <= mbs_pkg::THRESH_RESET;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      vo_r     <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      slot_r <= slot_nxt;
      seen_r <= seen_nxt;
      if (cfg_valid) begin
        thresh_r <= cfg_data;
      end
      if (rdy1) v1_r <= accept && warm_done;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cur1_r <= in_tdata;
      fe1_r  <= in_tlast;
    end
    if (rdy2) fe2_r <= fe1_r;
    if (rdy3) fe3_r <= fe2_r;
    if (rdy4) fe4_r <= fe3_r;
    if (rdyo) begin
      gray_o_r <= gray;
      fg_o_r   <= fg;
      fe_o_r   <= fe4_r;
    end
  end

  mbs_history_mem u_mem (
    .clk     (clk),
    .rd_en   (ctl.ld1),
    .rd_addr (pos_r),
    .rd_row  (row),
    .wr_en   (accept),
    .wr_addr (pos_r),
    .wr_slot (slot_r),
    .wr_pix  (in_tdata)
  );

  mbs_median u_median (
    .clk  (clk),
    .ctl  (ctl),
    .row  (row),
    .cur  (cur1_r),
    .diff (diff)
  );

  mbs_gray u_gray (
    .clk        (clk),
    .ctl        (ctl),
    .diff       (diff),
    .threshold  (thresh_r),
    .gray       (gray),
    .foreground (fg)
  );

  assign cfg_ready  = rst_n;
  assign out_tvalid = vo_r;
  assign out_tdata  = gray_o_r;
  assign out_tuser  = fg_o_r;
  assign out_tlast  = fe_o_r;

  // A frame end always restarts the position count.
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (pos_r == '0))
    else $error("pixel position not cleared after frame end");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= mbs_pkg::SLOT_W'(mbs_pkg::HISTORY_FRAMES - 1))
    else $error("oldest slot out of range");

  // No result may enter the pipeline before the history is full.
  a_no_warmup_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy1 && !warm_done) |=> !v1_r)
    else $error("result issued during warm-up");

endmodule
